FILE: hdl/sqks_pkg.sv
// Shared types and codes for the shifting queue with key search.
`timescale 1ns / 1ps
`default_nettype none

package sqks_pkg;

  localparam int unsigned TICKET_W = 16;
  localparam int unsigned NAME_W   = 64;
  localparam int unsigned CMD_W    = 2;
  localparam int unsigned STAT_W   = 2;
  localparam int unsigned POS_W    = 8;
  localparam int unsigned SIZE_W   = 8;
  localparam int unsigned CAP_W    = 8;

  localparam logic [CAP_W-1:0] CAP_RESET = 8'd100;

  // Command codes
  localparam logic [CMD_W-1:0] CMD_ENQ      = 2'd0;
  localparam logic [CMD_W-1:0] CMD_DEQ      = 2'd1;
  localparam logic [CMD_W-1:0] CMD_FIND_TKT = 2'd2;
  localparam logic [CMD_W-1:0] CMD_FIND_NM  = 2'd3;

  // Status codes
  localparam logic [STAT_W-1:0] STAT_DONE  = 2'd0;
  localparam logic [STAT_W-1:0] STAT_FULL  = 2'd1;
  localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd2;
  localparam logic [STAT_W-1:0] STAT_MISS  = 2'd3;

  typedef struct packed {
    logic [TICKET_W-1:0] ticket;
    logic [NAME_W-1:0]   name;
  } entry_t;

  typedef enum logic [1:0] {
    OP_HOLD   = 2'd0,
    OP_LOAD   = 2'd1,
    OP_SHIFT  = 2'd2,
    OP_ROTATE = 2'd3
  } cell_op_e;

  // Broadcast to every cell of the chain
  typedef struct packed {
    cell_op_e op;
    entry_t   load;
  } cell_ctrl_t;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [POS_W-1:0]  position;
    entry_t            found;
    entry_t            head;
    logic [SIZE_W-1:0] size;
  } rsp_data_t;

endpackage

`default_nettype wire

FILE: hdl/sqks_if.sv
// Channel interfaces: request, response and capacity write.
`timescale 1ns / 1ps
`default_nettype none

interface sqks_req_if;
  import sqks_pkg::*;
  logic                valid;
  logic                ready;
  logic [CMD_W-1:0]    cmd;
  logic [TICKET_W-1:0] ticket;
  logic [NAME_W-1:0]   name_key;

  modport source (output valid, cmd, ticket, name_key, input ready);
  modport sink (input valid, cmd, ticket, name_key, output ready);
endinterface

interface sqks_rsp_if;
  import sqks_pkg::*;
  logic                valid;
  logic                ready;
  logic [STAT_W-1:0]   status;
  logic [POS_W-1:0]    position;
  logic [TICKET_W-1:0] found_ticket;
  logic [NAME_W-1:0]   found_name;
  logic [TICKET_W-1:0] head_ticket;
  logic [NAME_W-1:0]   head_name;
  logic [SIZE_W-1:0]   size;

  modport source (output valid, status, position, found_ticket, found_name,
                  head_ticket, head_name, size, input ready);
  modport sink (input valid, status, position, found_ticket, found_name,
                head_ticket, head_name, size, output ready);
endinterface

interface sqks_cfg_if;
  import sqks_pkg::*;
  logic             valid;
  logic             ready;
  logic [CAP_W-1:0] data;

  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

`default_nettype wire

FILE: hdl/sqks_cell.sv
// One storage cell of the queue chain: hold, load, shift toward head or rotate.
`timescale 1ns / 1ps
`default_nettype none

module sqks_cell #(
  parameter int unsigned CNT_W    = 8,
  parameter int unsigned CELL_IDX = 0
) (
  input  wire logic                clk_i,
  input  wire sqks_pkg::cell_ctrl_t ctrl_i,
  input  wire logic [CNT_W-1:0]    cnt_i,
  input  wire sqks_pkg::entry_t    nbr_i,
  input  wire sqks_pkg::entry_t    head_i,
  output sqks_pkg::entry_t         entry_o
);
  import sqks_pkg::*;

  localparam logic [CNT_W-1:0] MY_IDX = CNT_W'(CELL_IDX);

  entry_t entry_q, entry_d;

  always_comb begin
    entry_d = entry_q;
    unique case (ctrl_i.op)
      OP_HOLD: entry_d = entry_q;
      OP_LOAD: begin
        if (cnt_i == MY_IDX) entry_d = ctrl_i.load;
      end
      OP_SHIFT: entry_d = nbr_i;
      OP_ROTATE: begin
        // tail of the occupied part wraps around to the head entry
        entry_d = ((cnt_i - CNT_W'(1)) == MY_IDX) ? head_i : nbr_i;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;

endmodule

`default_nettype wire

FILE: hdl/shifting_queue_with_key_search_core.sv
// Top level: bounded queue built as a chain of cells, with key search.
// Enqueue and dequeue results are registered and valid in the cycle after the transfer.
// A search rotates the chain past the head comparator once per held entry (scan state),
// then the done state loads the result once the output register is free.
// One item in flight: the next transfer is taken once the result is out.
// Reset: held count and control clear, capacity returns to 100; cell storage is not reset.
`timescale 1ns / 1ps
`default_nettype none

module shifting_queue_with_key_search_core #(
  parameter int unsigned DEPTH = 128
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  sqks_req_if.sink    req_if,
  sqks_rsp_if.source  rsp_if,
  sqks_cfg_if.sink    cfg_if
);
  import sqks_pkg::*;

  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam int unsigned CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;
  localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(DEPTH);

  // Sequencer states
  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  logic [1:0]       state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [CNT_W-1:0] scan_q, scan_d;        // rotations done in this lap
  logic [CNT_W-1:0] fpos_q, fpos_d;        // one-based match position
  logic             hit_q, hit_d;          // a match has been latched
  logic             by_name_q, by_name_d;  // search key kind
  entry_t           key_q, key_d;
  entry_t           fent_q, fent_d;
  logic [CAP_W-1:0] cap_q;

  logic             out_valid_q;
  rsp_data_t        out_q, out_d;
  logic             out_load;
  logic             out_free;
  logic             req_xfer;

  cell_ctrl_t       ctrl;
  entry_t           cell_ent [DEPTH];
  entry_t           in_ent;
  entry_t           head_now;
  logic             full;
  logic             head_hit;

  // ---------------------------------------------------------------------------
  // Cell chain: cell 0 is the head, each cell takes from its upper neighbor
  // ---------------------------------------------------------------------------
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    entry_t nbr;
    if (i == DEPTH - 1) begin : g_last
      assign nbr = '0;
    end else begin : g_mid
      assign nbr = cell_ent[i+1];
    end
    sqks_cell #(
      .CNT_W   (CNT_W),
      .CELL_IDX(i)
    ) u_cell (
      .clk_i  (clk_i),
      .ctrl_i (ctrl),
      .cnt_i  (cnt_q),
      .nbr_i  (nbr),
      .head_i (cell_ent[0]),
      .entry_o(cell_ent[i])
    );
  end

  // ---------------------------------------------------------------------------
  // Capacity register; writes land only while idle
  // ---------------------------------------------------------------------------
  assign cfg_if.ready = (state_q == ST_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= CAP_RESET;
    end else if (cfg_if.valid && cfg_if.ready) begin
      cap_q <= cfg_if.data;
    end
  end

  // ---------------------------------------------------------------------------
  // Request side
  // ---------------------------------------------------------------------------
  assign out_free     = !out_valid_q || rsp_if.ready;
  assign req_if.ready = (state_q == ST_IDLE) && out_free;
  assign req_xfer     = req_if.valid && req_if.ready;

  assign in_ent.ticket = req_if.ticket;
  assign in_ent.name   = req_if.name_key;

  // Full at or above capacity, or at DEPTH when capacity is larger
  assign full = (CMP_W'(cnt_q) >= CMP_W'(cap_q)) || (cnt_q == DEPTH_C);

  assign head_now = (cnt_q != '0) ? cell_ent[0] : '0;

  assign head_hit = by_name_q ? (cell_ent[0].name == key_q.name)
                              : (cell_ent[0].ticket == key_q.ticket);

  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    scan_d    = scan_q;
    fpos_d    = fpos_q;
    hit_d     = hit_q;
    by_name_d = by_name_q;
    key_d     = key_q;
    fent_d    = fent_q;
    ctrl.op   = OP_HOLD;
    ctrl.load = in_ent;
    out_load  = 1'b0;
    out_d     = out_q;

    unique case (state_q)
      ST_IDLE: begin
        if (req_xfer) begin
          unique case (req_if.cmd)
            CMD_ENQ: begin
              out_load = 1'b1;
              out_d    = '0;
              if (full) begin
                out_d.status = STAT_FULL;
                out_d.head   = head_now;
                out_d.size   = SIZE_W'(cnt_q);
              end else begin
                ctrl.op      = OP_LOAD;
                cnt_d        = cnt_q + CNT_W'(1);
                out_d.status = STAT_DONE;
                out_d.head   = (cnt_q == '0) ? in_ent : cell_ent[0];
                out_d.size   = SIZE_W'(cnt_d);
              end
            end
            CMD_DEQ: begin
              out_load = 1'b1;
              out_d    = '0;
              if (cnt_q == '0) begin
                out_d.status = STAT_EMPTY;
              end else begin
                ctrl.op        = OP_SHIFT;
                cnt_d          = cnt_q - CNT_W'(1);
                out_d.status   = STAT_DONE;
                out_d.position = POS_W'(1);
                out_d.found    = cell_ent[0];
                out_d.head     = (cnt_q > CNT_W'(1)) ? cell_ent[1] : '0;
                out_d.size     = SIZE_W'(cnt_d);
              end
            end
            CMD_FIND_TKT, CMD_FIND_NM: begin
              key_d     = in_ent;
              by_name_d = (req_if.cmd == CMD_FIND_NM);
              hit_d     = 1'b0;
              fpos_d    = '0;
              fent_d    = '0;
              scan_d    = '0;
              state_d   = (cnt_q == '0) ? ST_DONE : ST_SCAN;
            end
          endcase
        end
      end

      ST_SCAN: begin
        // head holds original entry scan_q; first match wins
        ctrl.op = OP_ROTATE;
        if (!hit_q && head_hit) begin
          hit_d  = 1'b1;
          fpos_d = scan_q + CNT_W'(1);
          fent_d = cell_ent[0];
        end
        scan_d = scan_q + CNT_W'(1);
        if (scan_q == cnt_q - CNT_W'(1)) begin
          state_d = ST_DONE;
        end
      end

      ST_DONE: begin
        if (out_free) begin
          out_load       = 1'b1;
          out_d.status   = hit_q ? STAT_DONE : STAT_MISS;
          out_d.position = POS_W'(fpos_q);
          out_d.found    = fent_q;
          out_d.head     = head_now;
          out_d.size     = SIZE_W'(cnt_q);
          state_d        = ST_IDLE;
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      scan_q      <= '0;
      hit_q       <= 1'b0;
      fpos_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      scan_q  <= scan_d;
      hit_q   <= hit_d;
      fpos_q  <= fpos_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (rsp_if.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    by_name_q <= by_name_d;
    key_q     <= key_d;
    fent_q    <= fent_d;
    if (out_load) begin
      out_q <= out_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Response side
  // ---------------------------------------------------------------------------
  assign rsp_if.valid        = out_valid_q;
  assign rsp_if.status       = out_q.status;
  assign rsp_if.position     = out_q.position;
  assign rsp_if.found_ticket = out_q.found.ticket;
  assign rsp_if.found_name   = out_q.found.name;
  assign rsp_if.head_ticket  = out_q.head.ticket;
  assign rsp_if.head_name    = out_q.head.name;
  assign rsp_if.size         = out_q.size;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= DEPTH_C)
    else $error("held count above DEPTH");

  a_scan_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN) |-> (scan_q < cnt_q))
    else $error("rotation count past the occupied part");

  a_scan_cnt_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN) |=> $stable(cnt_q))
    else $error("held count changed during a search lap");

  a_hit_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == ST_DONE) && hit_q) |-> (fpos_q != '0) && (fpos_q <= cnt_q))
    else $error("match position out of range");

  a_no_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !rsp_if.ready) |-> !out_load)
    else $error("result overwritten before transfer");

endmodule

`default_nettype wire

FILE: bench/tb.sv
// Testbench for the shifting queue core: self-checking random and directed traffic.
`timescale 1ns / 1ps
`default_nettype none

module tb;
  import sqks_pkg::*;

  localparam int unsigned QDEPTH      = 128;
  localparam int unsigned STALL_LIMIT = 3000;  // cycles with no transfer on any channel
  localparam int unsigned HOLD_CYCLES = 400;   // long response hold-off
  localparam int unsigned ERR_PRINTS  = 40;

  logic clk_i;
  logic rst_ni;

  sqks_req_if req_ch ();
  sqks_rsp_if rsp_ch ();
  sqks_cfg_if cfg_ch ();

  shifting_queue_with_key_search_core #(
    .DEPTH (QDEPTH)
  ) uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_if (req_ch.sink),
    .rsp_if (rsp_ch.source),
    .cfg_if (cfg_ch.sink)
  );

  // Shadow of the block: held entries (head first) and the capacity register.
  entry_t            held_q[$];
  logic [CAP_W-1:0]  cap_reg = CAP_RESET;
  rsp_data_t         pending_rsp_q[$];

  int unsigned err_cnt;
  int unsigned cmd_cnt[4];
  int unsigned stat_cnt[4];
  int unsigned cap_writes;
  bit          steady;    // no idling on either side
  bit          hold_req;  // ask the receiver for a long hold-off

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Next state of the queue and the response for one command.
  function automatic rsp_data_t predict_queue_op(logic [CMD_W-1:0]    cmd,
                                                 logic [TICKET_W-1:0] tk,
                                                 logic [NAME_W-1:0]   nm);
    rsp_data_t   r;
    entry_t      e;
    int unsigned lim;
    r   = '0;
    lim = (cap_reg > QDEPTH) ? QDEPTH : cap_reg;
    case (cmd)
      CMD_ENQ: begin
        if (held_q.size() >= lim) begin
          r.status = STAT_FULL;
        end else begin
          e.ticket = tk;
          e.name   = nm;
          held_q.push_back(e);
        end
      end
      CMD_DEQ: begin
        if (held_q.size() == 0) begin
          r.status = STAT_EMPTY;
        end else begin
          r.found    = held_q.pop_front();
          r.position = 8'd1;
        end
      end
      default: begin
        r.status = STAT_MISS;
        for (int i = 0; i < held_q.size(); i++) begin
          if ((cmd == CMD_FIND_TKT) ? (held_q[i].ticket == tk) : (held_q[i].name == nm)) begin
            r.status   = STAT_DONE;
            r.position = POS_W'(i + 1);
            r.found    = held_q[i];
            break;
          end
        end
      end
    endcase
    if (held_q.size() > 0) r.head = held_q[0];
    r.size = SIZE_W'(held_q.size());
    return r;
  endfunction

  // One request transfer; the expectation is queued at the accepting edge.
  task automatic send_item(logic [CMD_W-1:0] cmd, logic [TICKET_W-1:0] tk,
                           logic [NAME_W-1:0] nm);
    rsp_data_t r;
    while (!steady && $urandom_range(99) < 12) begin
      req_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    req_ch.valid    <= 1'b1;
    req_ch.cmd      <= cmd;
    req_ch.ticket   <= tk;
    req_ch.name_key <= nm;
    do @(posedge clk_i); while (!req_ch.ready);
    r = predict_queue_op(cmd, tk, nm);
    pending_rsp_q.push_back(r);
    cmd_cnt[cmd]++;
    stat_cnt[r.status]++;
  endtask

  // Stop offering and wait until every response is back.
  task automatic drain;
    req_ch.valid <= 1'b0;
    while (pending_rsp_q.size() > 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_capacity(logic [CAP_W-1:0] value);
    drain();
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= value;
    do @(posedge clk_i); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    cap_reg = value;
    cap_writes++;
  endtask

  // Random command; most searches aim at a held key, small key pools force duplicates.
  task automatic send_random_item;
    logic [CMD_W-1:0]    cmd;
    logic [TICKET_W-1:0] tk;
    logic [NAME_W-1:0]   nm;
    int unsigned         r;
    r  = $urandom_range(99);
    cmd = (r < 40) ? CMD_ENQ : (r < 65) ? CMD_DEQ : (r < 82) ? CMD_FIND_TKT : CMD_FIND_NM;
    tk = ($urandom_range(99) < 30) ? TICKET_W'($urandom_range(7)) : TICKET_W'($urandom);
    nm = ($urandom_range(99) < 30) ? NAME_W'($urandom_range(7)) : {$urandom, $urandom};
    if ((cmd == CMD_FIND_TKT || cmd == CMD_FIND_NM) && held_q.size() > 0 &&
        $urandom_range(99) < 70) begin
      r = $urandom_range(held_q.size() - 1);
      if (cmd == CMD_FIND_TKT) tk = held_q[r].ticket;
      else nm = held_q[r].name;
    end
    send_item(cmd, tk, nm);
  endtask

  task automatic test_directed;
    send_item(CMD_DEQ, '0, '0);                        // empty refusal
    send_item(CMD_FIND_TKT, 16'h1234, '0);             // miss on empty queue
    send_item(CMD_FIND_NM, '0, '1);
    send_item(CMD_ENQ, '0, '0);
    send_item(CMD_ENQ, '1, '1);
    send_item(CMD_ENQ, '1, 64'h0123_4567_89ab_cdef);   // duplicate ticket
    send_item(CMD_ENQ, 16'h8000, 64'h8000_0000_0000_0000);
    send_item(CMD_FIND_TKT, '1, '0);                   // nearest-head duplicate wins
    send_item(CMD_FIND_NM, '0, 64'h0123_4567_89ab_cdef);
    send_item(CMD_FIND_NM, '1, '0);
    send_item(CMD_FIND_TKT, 16'h8000, '1);             // hit at tail
    send_item(CMD_FIND_TKT, 16'h7fff, '0);
    send_item(CMD_FIND_NM, 16'h8000, 64'h5555_5555_5555_5555);
    repeat (5) send_item(CMD_DEQ, '0, '0);            // last one refused
    send_item(CMD_ENQ, 16'h5a5a, 64'ha5a5_a5a5_a5a5_a5a5);
    send_item(CMD_FIND_NM, 16'h5a5a, 64'ha5a5_a5a5_a5a5_a5a5);
    send_item(CMD_DEQ, '0, '0);
    drain();
  endtask

  task automatic test_capacity_limits;
    // Capacity above depth: fills to depth, then refuses.
    write_capacity('1);
    for (int i = 0; i < QDEPTH; i++) send_item(CMD_ENQ, TICKET_W'($urandom), {$urandom, $urandom});
    send_item(CMD_ENQ, '1, '1);
    send_item(CMD_FIND_TKT, held_q[QDEPTH-1].ticket, '0);
    send_item(CMD_FIND_NM, '0, held_q[QDEPTH-1].name);
    send_item(CMD_FIND_NM, '0, ~held_q[0].name ^ 64'h1);
    write_capacity(8'(QDEPTH));
    send_item(CMD_ENQ, '0, '0);
    // Capacity lowered below the held count: entries stay, enqueue refused.
    write_capacity(8'd5);
    send_item(CMD_ENQ, '0, '0);
    while (held_q.size() > 4) send_item(CMD_DEQ, '0, '0);
    send_item(CMD_ENQ, 16'hbeef, '1);
    send_item(CMD_ENQ, 16'hbeef, '0);
    // Capacity zero: every enqueue refused.
    write_capacity(8'd0);
    send_item(CMD_ENQ, '0, '0);
    while (held_q.size() > 0) send_item(CMD_DEQ, '0, '0);
    send_item(CMD_DEQ, '0, '0);
    send_item(CMD_ENQ, '1, '1);
    write_capacity(8'd1);
    send_item(CMD_ENQ, 16'h0001, 64'h1);
    send_item(CMD_ENQ, 16'h0002, 64'h2);
    drain();
  endtask

  task automatic test_random_traffic;
    logic [CAP_W-1:0] caps[9];
    caps = '{8'd8, 8'd255, 8'd3, 8'd128, 8'd1, 8'd100, 8'd0, 8'd16, 8'd0};
    caps[8] = CAP_W'($urandom_range(1, QDEPTH));
    for (int p = 0; p < 9; p++) begin
      write_capacity(caps[p]);
      steady = (p == 2);
      repeat (90) send_random_item();
    end
    steady = 1'b0;
    drain();
  endtask

  // Receiver stalls for a long stretch while requests keep coming.
  task automatic test_backpressure;
    write_capacity(8'd16);
    hold_req = 1'b1;
    repeat (40) send_random_item();
    drain();
  endtask

  // Response side: random ready, optional long hold-off.
  initial begin
    rsp_ch.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        rsp_ch.ready <= 1'b0;
        for (int k = 0; k < HOLD_CYCLES; k++) @(posedge clk_i);
        hold_req = 1'b0;
      end else begin
        rsp_ch.ready <= steady || ($urandom_range(99) >= 12);
      end
    end
  end

  task automatic compare_field(string fld, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      err_cnt++;
      if (err_cnt <= ERR_PRINTS)
        $display("%0t ns: %s mismatch, expected %h actual %h", $time, fld, want, got);
    end
  endtask

  // Response checker: each transfer against the oldest expectation.
  always @(posedge clk_i) begin
    rsp_data_t w;
    if (rst_ni && rsp_ch.valid && rsp_ch.ready) begin
      if (pending_rsp_q.size() == 0) begin
        err_cnt++;
        if (err_cnt <= ERR_PRINTS)
          $display("%0t ns: response with nothing outstanding, expected none actual status %h",
                   $time, rsp_ch.status);
      end else begin
        w = pending_rsp_q.pop_front();
        compare_field("status", 64'(w.status), 64'(rsp_ch.status));
        compare_field("position", 64'(w.position), 64'(rsp_ch.position));
        compare_field("found_ticket", 64'(w.found.ticket), 64'(rsp_ch.found_ticket));
        compare_field("found_name", w.found.name, rsp_ch.found_name);
        compare_field("head_ticket", 64'(w.head.ticket), 64'(rsp_ch.head_ticket));
        compare_field("head_name", w.head.name, rsp_ch.head_name);
        compare_field("size", 64'(w.size), 64'(rsp_ch.size));
      end
    end
  end

  // Watchdog: ends the run once no channel has moved a transfer for too long.
  initial begin
    int unsigned quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk_i);
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
          (cfg_ch.valid && cfg_ch.ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("%0t ns: no transfer for %0d cycles, %0d responses outstanding",
             $time, STALL_LIMIT, pending_rsp_q.size());
    $display("tb failed");
    $finish;
  end

  initial begin
    rst_ni          <= 1'b0;
    req_ch.valid    <= 1'b0;
    req_ch.cmd      <= CMD_ENQ;
    req_ch.ticket   <= '0;
    req_ch.name_key <= '0;
    cfg_ch.valid    <= 1'b0;
    cfg_ch.data     <= '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_capacity_limits();
    test_random_traffic();
    test_backpressure();

    drain();
    repeat (QDEPTH + 20) @(posedge clk_i);
    $display("covered %0d enqueues, %0d dequeues, %0d searches over %0d capacity settings",
             cmd_cnt[CMD_ENQ], cmd_cnt[CMD_DEQ], cmd_cnt[CMD_FIND_TKT] + cmd_cnt[CMD_FIND_NM],
             cap_writes + 1);
    $display("outcomes: %0d done or found, %0d full, %0d empty, %0d not found; %0d errors",
             stat_cnt[STAT_DONE], stat_cnt[STAT_FULL], stat_cnt[STAT_EMPTY],
             stat_cnt[STAT_MISS], err_cnt);
    if (err_cnt == 0 && pending_rsp_q.size() == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
